FILE: rtl/ebf_pkg.sv
// ----------------------------------------------------------------------------
// ebf_pkg
// Shared types and constants of the event block framer: block geometry,
// header field widths, queue entry layout and back-end sequencer states.
// ----------------------------------------------------------------------------
package ebf_pkg;

  // Block geometry
  localparam int BLOCK_WORDS   = 512;
  localparam int HEADER_WORDS  = 2;
  localparam int PAYLOAD_WORDS = BLOCK_WORDS - HEADER_WORDS;
  localparam int WIB_W         = $clog2(PAYLOAD_WORDS);

  // Field widths
  localparam int DATA_W   = 64;
  localparam int TOTAL_W  = 20;
  localparam int DONE_W   = 21;
  localparam int SRC_W    = 12;
  localparam int TRIG_W   = 20;
  localparam int BLKNUM_W = 11;
  localparam int COUNT_W  = 10;
  localparam int MAGIC_W  = 16;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-1:0] REG_MAGIC_ADDR = 3'd0;
  localparam logic [MAGIC_W-1:0] MAGIC_RESET   = 16'h475A;

  // Request queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One classified request: payload word plus its prepared header words
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [DATA_W-1:0] hdr1;
    logic [DATA_W-1:0] hdr2;
    logic              has_hdr;
    logic              last;
  } ebf_entry_t;

  // Back-end output phase
  typedef enum logic [1:0] {
    PH_HDR1,
    PH_HDR2,
    PH_DATA
  } ebf_phase_t;

endpackage

FILE: rtl/ebf_front.sv
// ----------------------------------------------------------------------------
// ebf_front
// Accepts payload words, tracks event and block position, and builds the
// header words for requests that open a block.
// ----------------------------------------------------------------------------
module ebf_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ebf_pkg::MAGIC_W-1:0] magic_word,
  input  logic                        in_valid,
  input  logic [ebf_pkg::DATA_W-1:0]  in_data_word,
  input  logic [ebf_pkg::TOTAL_W-1:0] in_event_words,
  input  logic [ebf_pkg::SRC_W-1:0]   in_source_id,
  input  logic [ebf_pkg::TRIG_W-1:0]  in_trigger_id,
  input  logic                        push_en,
  output ebf_pkg::ebf_entry_t         push_entry
);
  import ebf_pkg::*;

  logic [DONE_W-1:0]   words_done_r,   words_done_nxt;
  logic [BLKNUM_W-1:0] block_number_r, block_number_nxt;
  logic [WIB_W-1:0]    wib_r,          wib_nxt;

  logic [DONE_W:0]     done_inc;
  logic [DONE_W-1:0]   total_ext;
  logic                final_word;
  logic                block_start;
  logic [DONE_W-1:0]   remaining;
  logic                last_blk;
  logic [DONE_W-1:0]   count_full;
  logic [COUNT_W-1:0]  count;
  logic [WIB_W:0]      wib_inc;

  // Classify the request
  always_comb begin
    total_ext   = DONE_W'(in_event_words);
    done_inc    = {1'b0, words_done_r} + (DONE_W+1)'(1);
    final_word  = done_inc >= (DONE_W+1)'(in_event_words);
    block_start = (wib_r == '0);
    remaining   = (total_ext > words_done_r) ? (total_ext - words_done_r)
                                             : DONE_W'(1);
    last_blk    = remaining <= DONE_W'(PAYLOAD_WORDS);
    count_full  = last_blk ? remaining : DONE_W'(PAYLOAD_WORDS);
    count       = count_full[COUNT_W-1:0];
  end

  // Build the request entry
  always_comb begin
    push_entry.data    = in_data_word;
    push_entry.hdr1    = {magic_word, 5'd0, block_number_r,
                          (block_number_r == '0), last_blk, 20'd0, count};
    push_entry.hdr2    = {20'd0, in_source_id, 12'd0, in_trigger_id};
    push_entry.has_hdr = block_start;
    push_entry.last    = final_word;
  end

  // Advance position; clear on the event's final word
  always_comb begin
    words_done_nxt   = words_done_r;
    block_number_nxt = block_number_r;
    wib_nxt          = wib_r;
    wib_inc          = {1'b0, wib_r} + (WIB_W+1)'(1);
    if (in_valid && push_en) begin
      if (final_word) begin
        words_done_nxt   = '0;
        block_number_nxt = '0;
        wib_nxt          = '0;
      end else begin
        words_done_nxt = done_inc[DONE_W-1:0];
        if (wib_inc >= (WIB_W+1)'(PAYLOAD_WORDS)) begin
          wib_nxt          = '0;
          block_number_nxt = block_number_r + BLKNUM_W'(1);
        end else begin
          wib_nxt = wib_inc[WIB_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_done_r   <= '0;
      block_number_r <= '0;
      wib_r          <= '0;
    end else begin
      words_done_r   <= words_done_nxt;
      block_number_r <= block_number_nxt;
      wib_r          <= wib_nxt;
    end
  end

endmodule

FILE: rtl/ebf_queue.sv
// ----------------------------------------------------------------------------
// ebf_queue
// Small request queue between the front and back ends.
// ----------------------------------------------------------------------------
module ebf_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ebf_pkg::ebf_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output ebf_pkg::ebf_entry_t head
);
  import ebf_pkg::*;

  ebf_entry_t        slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   fill_r,   fill_nxt;

  assign full  = (fill_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (fill_r == '0);
  assign head  = slot_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Store requests
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: rtl/ebf_back.sv
// ----------------------------------------------------------------------------
// ebf_back
// Emits each queued request as two headers and a payload word, or as the
// payload word alone, through a registered output stage.
// ----------------------------------------------------------------------------
module ebf_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  ebf_pkg::ebf_entry_t        q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ebf_pkg::DATA_W-1:0] out_word,
  output logic                       out_is_header,
  output logic                       out_run_last,
  output logic                       out_event_end
);
  import ebf_pkg::*;

  ebf_phase_t        phase_r, phase_nxt;
  logic              vld_r, vld_nxt;
  logic [DATA_W-1:0] word_r, word_nxt;
  logic              hdr_r, hdr_nxt;
  logic              rlast_r, rlast_nxt;
  logic              eend_r, eend_nxt;
  logic              load;

  // Output register takes a new word when empty or being drained
  assign load = !vld_r || !out_stall;

  always_comb begin
    phase_nxt = phase_r;
    vld_nxt   = vld_r && out_stall;
    word_nxt  = word_r;
    hdr_nxt   = hdr_r;
    rlast_nxt = rlast_r;
    eend_nxt  = eend_r;
    q_pop     = 1'b0;
    if (load && !q_empty) begin
      vld_nxt = 1'b1;
      unique case (phase_r)
        PH_HDR1: begin
          if (q_head.has_hdr) begin
            word_nxt  = q_head.hdr1;
            hdr_nxt   = 1'b1;
            rlast_nxt = 1'b0;
            eend_nxt  = 1'b0;
            phase_nxt = PH_HDR2;
          end else begin
            word_nxt  = q_head.data;
            hdr_nxt   = 1'b0;
            rlast_nxt = 1'b1;
            eend_nxt  = q_head.last;
            q_pop     = 1'b1;
          end
        end
        PH_HDR2: begin
          word_nxt  = q_head.hdr2;
          hdr_nxt   = 1'b1;
          rlast_nxt = 1'b0;
          eend_nxt  = 1'b0;
          phase_nxt = PH_DATA;
        end
        PH_DATA: begin
          word_nxt  = q_head.data;
          hdr_nxt   = 1'b0;
          rlast_nxt = 1'b1;
          eend_nxt  = q_head.last;
          q_pop     = 1'b1;
          phase_nxt = PH_HDR1;
        end
        default: begin
          phase_nxt = PH_HDR1;
          vld_nxt   = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR1;
      vld_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      vld_r   <= vld_nxt;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    word_r  <= word_nxt;
    hdr_r   <= hdr_nxt;
    rlast_r <= rlast_nxt;
    eend_r  <= eend_nxt;
  end

  assign out_valid     = vld_r;
  assign out_word      = word_r;
  assign out_is_header = hdr_r;
  assign out_run_last  = rlast_r;
  assign out_event_end = eend_r;

endmodule

FILE: rtl/event_block_framer.sv
// ----------------------------------------------------------------------------
// event_block_framer
// Cuts events of 64-bit payload words into blocks and puts two header words
// in front of each block.
//
//   Port group | Direction | Handshake          | Carries
//   in_*       | input     | in_valid/in_stall  | payload word, length, ids
//   out_*      | output    | out_valid/out_stall| framed word and flags
//   APB        | input     | psel/penable       | magic_word at address 0
//
// One request enters per cycle while the queue has room. A request that opens
// a block leaves as three words, any other as one, all through the single
// output register, so a full block of PAYLOAD_WORDS requests leaves as
// BLOCK_WORDS output words. A request's words pass through a queue slot,
// then the output register. The four-entry queue absorbs header slots;
// in_stall is high only when it is full. Reset is synchronous and clears
// position state, queue and output valid; magic_word returns to its default.
// ----------------------------------------------------------------------------
module event_block_framer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ebf_pkg::DATA_W-1:0]  in_data_word,
  input  logic [ebf_pkg::TOTAL_W-1:0] in_event_words,
  input  logic [ebf_pkg::SRC_W-1:0]   in_source_id,
  input  logic [ebf_pkg::TRIG_W-1:0]  in_trigger_id,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ebf_pkg::DATA_W-1:0]  out_word,
  output logic                        out_is_header,
  output logic                        out_run_last,
  output logic                        out_event_end,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ebf_pkg::APB_AW-1:0]  paddr,
  input  logic [ebf_pkg::APB_DW-1:0]  pwdata,
  output logic [ebf_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import ebf_pkg::*;

  logic [MAGIC_W-1:0] magic_r, magic_nxt;
  logic               q_full;
  logic               q_empty;
  logic               q_pop;
  logic               push;
  ebf_entry_t         push_entry;
  ebf_entry_t         q_head;
  logic               addr_hit;

  // Configuration register
  assign pready   = 1'b1;
  assign addr_hit = (paddr[APB_AW-1:2] == REG_MAGIC_ADDR[APB_AW-1:2]);

  always_comb begin
    magic_nxt = magic_r;
    if (psel && penable && pwrite && addr_hit) begin
      magic_nxt = pwdata[MAGIC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= MAGIC_RESET;
    end else begin
      magic_r <= magic_nxt;
    end
  end

  assign prdata = addr_hit ? APB_DW'(magic_r) : '0;

  // Accept requests while the queue has room
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  ebf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .magic_word     (magic_r),
    .in_valid       (in_valid),
    .in_data_word   (in_data_word),
    .in_event_words (in_event_words),
    .in_source_id   (in_source_id),
    .in_trigger_id  (in_trigger_id),
    .push_en        (!q_full),
    .push_entry     (push_entry)
  );

  ebf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  ebf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .out_is_header (out_is_header),
    .out_run_last  (out_run_last),
    .out_event_end (out_event_end)
  );

endmodule

FILE: rtl/ebf_checker.sv
// ----------------------------------------------------------------------------
// ebf_checker
// Port-level checks of the event block framer, bound to the top level.
// ----------------------------------------------------------------------------
module ebf_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [ebf_pkg::DATA_W-1:0] out_word,
  input logic                       out_is_header,
  input logic                       out_run_last,
  input logic                       out_event_end
);
  import ebf_pkg::*;

  // Output register empties on reset
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // Header words never close a request or an event
  a_hdr_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_header |-> !out_run_last && !out_event_end)
    else $error("header word flagged as last");

  // Event end comes on the request's payload word
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_end |-> out_run_last)
    else $error("event end without run_last");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word)
      && $stable(out_is_header) && $stable(out_run_last))
    else $error("stalled result changed");

endmodule

bind event_block_framer ebf_checker u_ebf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_word      (out_word),
  .out_is_header (out_is_header),
  .out_run_last  (out_run_last),
  .out_event_end (out_event_end)
);
